[design/ikq_pkg.sv]
package ikq_pkg;

   localparam int DEF_MAX_ITEMS    = 64;
   localparam int DEF_PAYLOAD_BITS = 32;
   localparam int KEY_W            = 32;
   localparam int PAYLOAD_W        = 32;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_POP,
      OP_DEC,
      OP_PIV,
      OP_IINC,
      OP_CAPI,
      OP_SWJ,
      OP_JDEC,
      OP_WRJ,
      OP_WRI,
      OP_WRR,
      OP_PUSHR,
      OP_PUSHL,
      OP_PUSHM,
      OP_ORD,
      OP_OLD,
      OP_ONEXT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic sp_zero;
      logic range_bad;
      logic low;
      logic i_at_end;
      logic i_ge_j;
      logic out_last;
   } status_type;

endpackage

[design/ikq_if.sv]
interface ikq_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] key;
   logic [31:0]        payload;
   logic               last_in;
   modport source (output valid, key, payload, last_in, input ready);
   modport sink   (input valid, key, payload, last_in, output ready);
endinterface

interface ikq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sorted_key;
   logic [31:0]        sorted_payload;
   logic               last_out;
   logic               overflowed;
   modport source (output valid, sorted_key, sorted_payload, last_out, overflowed,
                   input ready);
   modport sink   (input valid, sorted_key, sorted_payload, last_out, overflowed,
                   output ready);
endinterface

interface ikq_csr_if;
   logic valid;
   logic ready;
   logic descending;
   modport source (output valid, descending, input ready);
   modport sink   (input valid, descending, output ready);
endinterface

[design/ikq_ctrl.sv]
module ikq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   input  logic                rsp_ready,
   input  ikq_pkg::status_type st,
   output ikq_pkg::cmd_type    cmd,
   output logic                req_ready
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_POP, S_DEC, S_PIV, S_SCAN_I, S_SCAN_J, S_SWAP_W,
      S_FIX_I, S_FIX_R, S_PUSH_R, S_PUSH_L, S_PUSH_M, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = ikq_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.op = ikq_pkg::OP_LOAD;
               if (req_last) state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.op   = ikq_pkg::OP_INIT;
            state_in = S_POP;
         end
         S_POP: begin
            if (st.sp_zero) begin
               state_in = S_OUT_RD;
            end else begin
               cmd.op   = ikq_pkg::OP_POP;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (st.range_bad) begin
               state_in = S_POP;
            end else begin
               cmd.op   = ikq_pkg::OP_DEC;
               state_in = S_PIV;
            end
         end
         S_PIV: begin
            cmd.op   = ikq_pkg::OP_PIV;
            state_in = S_SCAN_I;
         end
         S_SCAN_I: begin
            if (st.low && st.i_at_end) begin
               state_in = S_PUSH_M;
            end else if (st.low) begin
               cmd.op = ikq_pkg::OP_IINC;
            end else begin
               cmd.op   = ikq_pkg::OP_CAPI;
               state_in = S_SCAN_J;
            end
         end
         S_SCAN_J: begin
            if (st.low) begin
               cmd.op   = ikq_pkg::OP_SWJ;
               state_in = S_SWAP_W;
            end else if (st.i_ge_j) begin
               state_in = S_FIX_I;
            end else begin
               cmd.op = ikq_pkg::OP_JDEC;
            end
         end
         S_SWAP_W: begin
            cmd.op   = ikq_pkg::OP_WRJ;
            state_in = S_SCAN_I;
         end
         S_FIX_I: begin
            cmd.op   = ikq_pkg::OP_WRI;
            state_in = S_FIX_R;
         end
         S_FIX_R: begin
            cmd.op   = ikq_pkg::OP_WRR;
            state_in = S_PUSH_R;
         end
         S_PUSH_R: begin
            cmd.op   = ikq_pkg::OP_PUSHR;
            state_in = S_PUSH_L;
         end
         S_PUSH_L: begin
            cmd.op   = ikq_pkg::OP_PUSHL;
            state_in = S_POP;
         end
         S_PUSH_M: begin
            cmd.op   = ikq_pkg::OP_PUSHM;
            state_in = S_POP;
         end
         S_OUT_RD: begin
            cmd.op   = ikq_pkg::OP_ORD;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            cmd.op   = ikq_pkg::OP_OLD;
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               cmd.op   = ikq_pkg::OP_ONEXT;
               state_in = st.out_last ? S_IDLE : S_OUT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

[design/ikq_dp.sv]
module ikq_dp #(
   parameter int MaxItems    = ikq_pkg::DEF_MAX_ITEMS,
   parameter int PayloadBits = ikq_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ikq_pkg::cmd_type                    cmd,
   output ikq_pkg::status_type                 st,
   input  logic                                descending,
   input  logic signed [ikq_pkg::KEY_W-1:0]    req_key,
   input  logic [ikq_pkg::PAYLOAD_W-1:0]       req_payload,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic signed [ikq_pkg::KEY_W-1:0]    rsp_key,
   output logic [ikq_pkg::PAYLOAD_W-1:0]       rsp_payload,
   output logic                                rsp_last,
   output logic                                rsp_ovf
);

   localparam int IW = $clog2(MaxItems);
   localparam int CW = $clog2(MaxItems + 1);
   localparam int RW = ikq_pkg::KEY_W + PayloadBits;
   localparam int SW = 2 * IW;

   logic [RW-1:0] rec_mem [MaxItems];
   logic [SW-1:0] stk_mem [MaxItems];

   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in, sp_ff, sp_in;
   logic          ovf_ff, ovf_in;
   logic [IW-1:0] l_ff, l_in, r_ff, r_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [RW-1:0] piv_ff, piv_in, reci_ff, reci_in, rd_ff;
   logic [SW-1:0] srd_ff;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic signed [ikq_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [ikq_pkg::PAYLOAD_W-1:0]    rsp_pl_ff, rsp_pl_in;

   logic          mem_we, stk_we;
   logic [IW-1:0] mem_wa, mem_ra, stk_wa, stk_ra;
   logic [RW-1:0] mem_wd;
   logic          push_en;
   logic [IW-1:0] push_lo, push_hi;

   logic [63:0]          pl_wide, out_wide;
   logic [PayloadBits-1:0] pl_store;
   logic signed [ikq_pkg::KEY_W-1:0] rd_key, piv_key;
   logic [IW-1:0] s_lo, s_hi, r_m1;
   logic [CW-1:0] n_m1, sp_m1, k_p1;

   assign pl_wide  = 64'(req_payload);
   assign pl_store = pl_wide[PayloadBits-1:0];
   assign out_wide = 64'(rd_ff[PayloadBits-1:0]);
   assign rd_key   = rd_ff[RW-1 -: ikq_pkg::KEY_W];
   assign piv_key  = piv_ff[RW-1 -: ikq_pkg::KEY_W];
   assign s_lo     = srd_ff[SW-1 -: IW];
   assign s_hi     = srd_ff[IW-1:0];
   assign r_m1     = r_ff - IW'(1);
   assign n_m1     = n_ff - CW'(1);
   assign sp_m1    = sp_ff - CW'(1);
   assign k_p1     = CW'(k_ff) + CW'(1);

   assign st.sp_zero   = (sp_ff == '0);
   assign st.range_bad = (s_hi <= s_lo) || (CW'(s_hi) >= n_ff);
   assign st.low       = descending ? (rd_key >= piv_key) : (rd_key <= piv_key);
   assign st.i_at_end  = (i_ff == r_m1);
   assign st.i_ge_j    = (i_ff >= j_ff);
   assign st.out_last  = rsp_last_ff;

   always_comb begin
      cnt_in = cnt_ff;  n_in = n_ff;  sp_in = sp_ff;  ovf_in = ovf_ff;
      l_in = l_ff;  r_in = r_ff;  i_in = i_ff;  j_in = j_ff;  k_in = k_ff;
      piv_in = piv_ff;  reci_in = reci_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_last_in = rsp_last_ff;  rsp_ovf_in = rsp_ovf_ff;
      rsp_key_in = rsp_key_ff;  rsp_pl_in = rsp_pl_ff;
      mem_we = 1'b0;  mem_wa = i_ff;  mem_wd = rd_ff;  mem_ra = i_ff;
      stk_ra = sp_m1[IW-1:0];
      push_en = 1'b0;  push_lo = l_ff;  push_hi = r_ff;
      case (cmd.op)
         ikq_pkg::OP_LOAD: begin
            if (cnt_ff < CW'(MaxItems)) begin
               mem_we = 1'b1;
               mem_wa = cnt_ff[IW-1:0];
               mem_wd = {req_key, pl_store};
               cnt_in = cnt_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
            if (req_last) n_in = cnt_in;
         end
         ikq_pkg::OP_INIT: begin
            sp_in   = '0;
            k_in    = '0;
            push_en = (n_ff > CW'(1));
            push_lo = '0;
            push_hi = n_m1[IW-1:0];
         end
         ikq_pkg::OP_POP: sp_in = sp_m1;
         ikq_pkg::OP_DEC: begin
            l_in   = s_lo;
            r_in   = s_hi;
            mem_ra = s_hi;
         end
         ikq_pkg::OP_PIV: begin
            piv_in = rd_ff;
            i_in   = l_ff;
            j_in   = r_m1;
            mem_ra = l_ff;
         end
         ikq_pkg::OP_IINC: begin
            i_in   = i_ff + IW'(1);
            mem_ra = i_in;
         end
         ikq_pkg::OP_CAPI: begin
            reci_in = rd_ff;
            mem_ra  = j_ff;
         end
         ikq_pkg::OP_SWJ: mem_we = 1'b1;
         ikq_pkg::OP_JDEC: begin
            j_in   = j_ff - IW'(1);
            mem_ra = j_in;
         end
         ikq_pkg::OP_WRJ: begin
            mem_we = 1'b1;
            mem_wa = j_ff;
            mem_wd = reci_ff;
         end
         ikq_pkg::OP_WRI: begin
            mem_we = 1'b1;
            mem_wd = piv_ff;
         end
         ikq_pkg::OP_WRR: begin
            mem_we = 1'b1;
            mem_wa = r_ff;
            mem_wd = reci_ff;
         end
         ikq_pkg::OP_PUSHR: begin
            push_en = 1'b1;
            push_lo = i_ff + IW'(1);
         end
         ikq_pkg::OP_PUSHL: begin
            push_en = (i_ff != '0);
            push_hi = i_ff - IW'(1);
         end
         ikq_pkg::OP_PUSHM: begin
            push_en = 1'b1;
            push_hi = r_m1;
         end
         ikq_pkg::OP_ORD: mem_ra = k_ff;
         ikq_pkg::OP_OLD: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = rd_key;
            rsp_pl_in    = out_wide[ikq_pkg::PAYLOAD_W-1:0];
            rsp_last_in  = (k_p1 == n_ff);
            rsp_ovf_in   = ovf_ff;
         end
         ikq_pkg::OP_ONEXT: begin
            rsp_valid_in = 1'b0;
            if (rsp_last_ff) begin
               cnt_in = '0;
               ovf_in = 1'b0;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         default: ;
      endcase
      // Ranges of one element or less are never stacked.
      stk_we = push_en && (push_hi > push_lo) && (sp_in < CW'(MaxItems));
      stk_wa = sp_in[IW-1:0];
      if (stk_we) sp_in = sp_in + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (mem_we) rec_mem[mem_wa] <= mem_wd;
      rd_ff <= rec_mem[mem_ra];
      if (stk_we) stk_mem[stk_wa] <= {push_lo, push_hi};
      srd_ff <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sp_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      piv_ff      <= piv_in;
      reci_ff     <= reci_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_pl_ff   <= rsp_pl_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_key     = rsp_key_ff;
   assign rsp_payload = rsp_pl_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_ovf     = rsp_ovf_ff;

endmodule

[design/int_key_quicksort.sv]
// Record sorter. Records (signed key plus payload) arrive as transfers on the
// req_chan channel and are stored one per cycle until a transfer with last_in
// set; that record starts the sort. Records that arrive while the store holds
// MaxItems entries are dropped, and every result of that set is then marked
// overflowed. The last_in record starts the sort even when it is dropped.
// The sort is an in-place quicksort with the last element of each range as
// pivot, run by a state machine over one record memory with a single read port
// and a single write port, and a range stack memory. Its speed is bounded by
// the single read port of the record memory. The sorted run then leaves on
// rsp_chan: each result is read from the record memory, loaded into the output
// register and held until the receiver takes it, with last_out on the final
// one. A stalled receiver simply holds the current result; the block waits.
// No new records are accepted from the last_in transfer until the final result
// transfer. The descending bit is written on csr_chan, always ready, and
// should only change while the block is idle. Reset clears the record count,
// the stack pointer, the overflow flag and the direction (ascending) and
// leaves the block idle.
module int_key_quicksort #(
   parameter int MaxItems    = ikq_pkg::DEF_MAX_ITEMS,
   parameter int PayloadBits = ikq_pkg::DEF_PAYLOAD_BITS
) (
   input logic          clock,
   input logic          reset,
   ikq_req_if.sink      req_chan,
   ikq_rsp_if.source    rsp_chan,
   ikq_csr_if.sink      csr_chan
);

   ikq_pkg::cmd_type    cmd;
   ikq_pkg::status_type st;
   logic                descending_ff;

   // The direction register takes every configuration transfer.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         descending_ff <= csr_chan.descending;
      end
   end

   ikq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_in),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd),
      .req_ready (req_chan.ready)
   );

   ikq_dp #(
      .MaxItems    (MaxItems),
      .PayloadBits (PayloadBits)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .descending  (descending_ff),
      .req_key     (req_chan.key),
      .req_payload (req_chan.payload),
      .req_last    (req_chan.last_in),
      .rsp_valid   (rsp_chan.valid),
      .rsp_key     (rsp_chan.sorted_key),
      .rsp_payload (rsp_chan.sorted_payload),
      .rsp_last    (rsp_chan.last_out),
      .rsp_ovf     (rsp_chan.overflowed)
   );

   // Loading and emitting never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input accepted while a result is pending");

   // After the final result transfer the block is ready for a new set.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_out) |=> req_chan.ready)
      else $error("block not idle after final result");

   // A result is only presented after the sort of a set has begun.
   a_valid_needs_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> !req_chan.ready && !$past(req_chan.ready))
      else $error("result appeared while loading");

endmodule
